// ===== design/tasm_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and interface types of the throttle arming setpoint mapper.
package tasm_pkg;

   // Q1.12 throttle and floor values.
   localparam int THR_W = 13;
   localparam logic [THR_W-1:0] FULL_SCALE = 13'd4096;
   localparam logic [THR_W-1:0] ZERO_THR = 13'd4;

   // Arming counter.
   localparam int ZT_W = 7;
   localparam logic [ZT_W-1:0] ZT_MAX = 7'd127;
   localparam int ARM_TICKS_DEF = 100;

   // Setpoint arithmetic.
   localparam int VAL_W = 16;
   localparam int PROD_W = 28;
   localparam int ACC_W = 42;
   localparam logic [VAL_W-1:0] PCT_MAX = 16'd10000;
   localparam logic [13:0] PCT_SCALE = 14'd10000;
   localparam logic [PROD_W-1:0] SPEED_ROUND = 28'd2048;
   localparam logic [ACC_W-1:0] VOLT_ROUND = 42'd8388608;
   localparam int DIV_STEPS = 15;
   localparam int CNT_W = $clog2(DIV_STEPS);

   // Item kinds.
   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_FLOOR = 1'b1;

   // Source selection register codes.
   localparam logic [1:0] SEL_OFF = 2'd0;
   localparam logic [1:0] SEL_POT = 2'd1;
   localparam logic [1:0] SEL_CUSTOM = 2'd2;

   // Reported input source.
   localparam logic [1:0] SRC_NONE = 2'd0;
   localparam logic [1:0] SRC_POT = 2'd1;
   localparam logic [1:0] SRC_CUSTOM = 2'd2;
   localparam logic [1:0] SRC_HOST = 2'd3;

   // Motor states.
   localparam logic [2:0] MS_IDLE = 3'd0;
   localparam logic [2:0] MS_FAULT = 3'd1;
   localparam logic [2:0] MS_STOP = 3'd2;
   localparam logic [2:0] MS_RUN = 3'd3;

   // Control modes.
   localparam logic [1:0] RM_VOLTAGE = 2'd0;
   localparam logic [1:0] RM_SPEED = 2'd1;
   localparam logic [1:0] RM_TORQUE = 2'd2;

   // Setpoint kinds.
   localparam logic [1:0] SP_NONE = 2'd0;
   localparam logic [1:0] SP_SPEED = 2'd1;
   localparam logic [1:0] SP_TORQUE = 2'd2;
   localparam logic [1:0] SP_VOLT = 2'd3;

   // Register map.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam logic [2:0] REG_SOURCE_SELECT = 3'd0;
   localparam logic [2:0] REG_CUSTOM_PRESENT = 3'd1;
   localparam logic [2:0] REG_START_MODE = 3'd2;
   localparam logic [2:0] REG_MIN_SPEED = 3'd3;
   localparam logic [2:0] REG_MAX_SPEED = 3'd4;
   localparam logic [2:0] REG_MIN_CURRENT = 3'd5;
   localparam logic [2:0] REG_MAX_CURRENT = 3'd6;
   localparam logic [2:0] REG_MIN_VOLTAGE = 3'd7;

   typedef struct packed {
      logic [1:0]       source_select;
      logic             custom_present;
      logic [2:0]       start_mode;
      logic [15:0]      min_speed;
      logic [15:0]      max_speed;
      logic [15:0]      min_current;
      logic [15:0]      max_current;
      logic [THR_W-1:0] min_voltage_frac;
   } tasm_cfg_type;

   typedef struct packed {
      logic accept;
      logic mul1;
      logic mul2;
      logic div_step;
      logic load_out;
   } tasm_cmd_type;

   typedef struct packed {
      logic div_needed;
   } tasm_status_type;

endpackage

// ===== design/tasm_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer that steps one item through the setpoint datapath.
module tasm_ctrl
   import tasm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  tasm_status_type status,
   output tasm_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL1 = 3'd1;
   localparam logic [2:0] S_MUL2 = 3'd2;
   localparam logic [2:0] S_DIV = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      cmd = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            cnt_in = '0;
            state_in = status.div_needed ? S_DIV : S_DONE;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DONE: begin
            // The result register is reused only once its previous transfer is done.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register loaded while a result was still pending");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_MUL1))
      else $error("accepted item did not start the multiply sequence");

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && cnt_ff == CNT_W'(DIV_STEPS - 1)) |=> (state_ff == S_DONE))
      else $error("divider did not finish after its last step");
`endif

endmodule

// ===== design/tasm_dp.sv =====
`timescale 1ns / 1ps
// Datapath: source selection, arming interlock, setpoint multiply and divide, result register.
module tasm_dp
   import tasm_pkg::*;
#(
   parameter int ARM_TICKS = ARM_TICKS_DEF
)
(
   input  logic             clock,
   input  logic             reset,
   input  tasm_cmd_type     cmd,
   output tasm_status_type  status,
   input  tasm_cfg_type     cfg,
   input  logic             req_kind,
   input  logic [THR_W-1:0] req_floor_value,
   input  logic             req_usb_configured,
   input  logic [THR_W-1:0] req_pot_throttle,
   input  logic             req_pot_arm_request,
   input  logic             req_pot_active,
   input  logic [THR_W-1:0] req_custom_throttle,
   input  logic             req_custom_arm_request,
   input  logic             req_custom_active,
   input  logic [2:0]       req_motor_state,
   input  logic [1:0]       req_running_mode,
   output logic [1:0]       rsp_source,
   output logic             rsp_armed,
   output logic [THR_W-1:0] rsp_active_throttle,
   output logic             rsp_start_cmd,
   output logic [1:0]       rsp_start_mode_out,
   output logic             rsp_stop_cmd,
   output logic [1:0]       rsp_setpoint_kind,
   output logic [VAL_W-1:0] rsp_setpoint_value
);

   // Block state.
   logic             armed_ff, armed_in;
   logic [ZT_W-1:0]  zt_ff, zt_in;
   logic [THR_W-1:0] floor_ff, floor_in;
   logic [1:0]       src_ff, src_in;
   logic [THR_W-1:0] lthr_ff, lthr_in;

   // Decision results of the accepted item.
   logic             start_in, stop_in;
   logic [1:0]       mode_in, sp_in;
   logic             res_start_ff, res_stop_ff;
   logic [1:0]       res_mode_ff;

   // Input selection.
   logic             use_custom;
   logic [THR_W-1:0] thr_raw, thr_sat, fl_max, fl_eff;
   logic             arm_req, act;

   // Arithmetic operands and working registers.
   logic signed [16:0] diff_in, diff_ff;
   logic [PROD_W-1:0]  base_in, base_ff;
   logic [THR_W-1:0]   thr_ff;
   logic [1:0]         sp_kind_ff;
   logic signed [30:0] mul1_full;
   logic [PROD_W-1:0]  prod_ff;
   logic [ACC_W-1:0]   bias, scaled, acc_ff, dvs_ff;
   logic [DIV_STEPS-1:0] quo_ff;
   logic               div_ge;
   logic [PROD_W-1:0]  spd_sum;
   logic [17:0]        volt_q;
   logic [VAL_W-1:0]   value_in;

   // Output register.
   logic [1:0]       rsp_source_ff, rsp_mode_ff, rsp_kind_ff;
   logic             rsp_armed_ff, rsp_start_ff, rsp_stop_ff;
   logic [THR_W-1:0] rsp_thr_ff;
   logic [VAL_W-1:0] rsp_value_ff;

   assign use_custom = (cfg.source_select == SEL_CUSTOM) && cfg.custom_present;
   assign thr_raw = use_custom ? req_custom_throttle : req_pot_throttle;
   assign arm_req = use_custom ? req_custom_arm_request : req_pot_arm_request;
   assign act = use_custom ? req_custom_active : req_pot_active;
   assign thr_sat = (thr_raw > FULL_SCALE) ? FULL_SCALE : thr_raw;

   always_comb begin
      armed_in = armed_ff;
      zt_in = zt_ff;
      floor_in = floor_ff;
      src_in = src_ff;
      lthr_in = lthr_ff;
      start_in = 1'b0;
      mode_in = RM_VOLTAGE;
      stop_in = 1'b0;
      sp_in = SP_NONE;
      if (req_kind == KIND_FLOOR) begin
         floor_in = req_floor_value;
      end else if (req_usb_configured) begin
         src_in = SRC_HOST;
         armed_in = 1'b0;
         zt_in = '0;
         lthr_in = '0;
      end else if (cfg.source_select == SEL_OFF) begin
         src_in = SRC_NONE;
         armed_in = 1'b0;
         zt_in = '0;
         lthr_in = '0;
      end else begin
         src_in = use_custom ? SRC_CUSTOM : SRC_POT;
         lthr_in = thr_sat;
         if (req_motor_state == MS_IDLE || req_motor_state == MS_FAULT) begin
            if (req_motor_state == MS_FAULT) begin
               armed_in = 1'b0;
               zt_in = '0;
            end
            // Arming needs a run of consecutive ticks at zero throttle.
            if (!armed_in) begin
               if (thr_sat <= ZERO_THR) begin
                  if (zt_in < ZT_MAX) begin
                     zt_in = zt_in + 1'b1;
                  end
                  if (zt_in >= ZT_W'(ARM_TICKS)) begin
                     armed_in = 1'b1;
                  end
               end else begin
                  zt_in = '0;
               end
            end
         end
         if (req_motor_state == MS_IDLE && armed_in && arm_req && act) begin
            start_in = 1'b1;
            mode_in = (cfg.start_mode > 3'(RM_TORQUE)) ? RM_TORQUE : cfg.start_mode[1:0];
         end
         if (req_motor_state != MS_IDLE && req_motor_state != MS_FAULT &&
             req_motor_state != MS_STOP && (!arm_req || !act)) begin
            stop_in = 1'b1;
            armed_in = 1'b0;
            zt_in = '0;
            floor_in = '0;
         end
         if (req_motor_state == MS_RUN && act) begin
            case (req_running_mode)
               RM_SPEED: sp_in = SP_SPEED;
               RM_TORQUE: sp_in = SP_TORQUE;
               RM_VOLTAGE: sp_in = SP_VOLT;
               default: sp_in = SP_NONE;
            endcase
         end
      end
   end

   // The voltage floor already reflects a stop taken in the same tick.
   assign fl_max = (floor_in > cfg.min_voltage_frac) ? floor_in : cfg.min_voltage_frac;
   assign fl_eff = (fl_max > FULL_SCALE) ? FULL_SCALE : fl_max;

   // Every setpoint is base + throttle * slope, with base and slope from the mode.
   always_comb begin
      case (sp_in)
         SP_SPEED: begin
            diff_in = $signed({1'b0, cfg.max_speed}) - $signed({1'b0, cfg.min_speed});
            base_in = {cfg.min_speed, 12'd0};
         end
         SP_TORQUE: begin
            diff_in = $signed({1'b0, cfg.max_current}) - $signed({1'b0, cfg.min_current});
            base_in = {cfg.min_current, 12'd0};
         end
         SP_VOLT: begin
            diff_in = $signed(17'(FULL_SCALE - fl_eff));
            base_in = {3'd0, fl_eff, 12'd0};
         end
         default: begin
            diff_in = '0;
            base_in = '0;
         end
      endcase
   end

   assign mul1_full = $signed({1'b0, thr_ff}) * diff_ff + $signed({3'd0, base_ff});
   assign bias = (sp_kind_ff == SP_TORQUE) ? ACC_W'({cfg.max_current, 11'd0}) : VOLT_ROUND;
   assign scaled = ({14'd0, prod_ff} * ACC_W'(PCT_SCALE)) + bias;
   assign div_ge = (acc_ff >= dvs_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         zt_ff <= '0;
         floor_ff <= '0;
         src_ff <= SRC_POT;
         lthr_ff <= '0;
         res_start_ff <= 1'b0;
         res_stop_ff <= 1'b0;
      end else if (cmd.accept) begin
         armed_ff <= armed_in;
         zt_ff <= zt_in;
         floor_ff <= floor_in;
         src_ff <= src_in;
         lthr_ff <= lthr_in;
         res_start_ff <= start_in;
         res_stop_ff <= stop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         res_mode_ff <= mode_in;
         sp_kind_ff <= sp_in;
         thr_ff <= thr_sat;
         diff_ff <= diff_in;
         base_ff <= base_in;
      end
      if (cmd.mul1) begin
         prod_ff <= mul1_full[PROD_W-1:0];
      end
      if (cmd.mul2) begin
         acc_ff <= scaled;
         dvs_ff <= {cfg.max_current, 26'd0};
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         // Restoring division; the top quotient bit flags an out-of-range result.
         if (div_ge) begin
            acc_ff <= acc_ff - dvs_ff;
         end
         dvs_ff <= dvs_ff >> 1;
         quo_ff <= {quo_ff[DIV_STEPS-2:0], div_ge};
      end
   end

   assign status.div_needed = (sp_kind_ff == SP_TORQUE) && (cfg.max_current != 16'd0);

   assign spd_sum = prod_ff + SPEED_ROUND;
   assign volt_q = acc_ff[ACC_W-1:24];

   always_comb begin
      case (sp_kind_ff)
         SP_SPEED: value_in = spd_sum[PROD_W-1:12];
         SP_TORQUE: begin
            if (cfg.max_current == 16'd0) begin
               value_in = '0;
            end else if (quo_ff[DIV_STEPS-1] || (quo_ff[DIV_STEPS-2:0] > 14'(PCT_MAX))) begin
               value_in = PCT_MAX;
            end else begin
               value_in = VAL_W'(quo_ff[DIV_STEPS-2:0]);
            end
         end
         SP_VOLT: value_in = (volt_q > 18'(PCT_MAX)) ? PCT_MAX : VAL_W'(volt_q);
         default: value_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_source_ff <= src_ff;
         rsp_armed_ff <= armed_ff;
         rsp_thr_ff <= lthr_ff;
         rsp_start_ff <= res_start_ff;
         rsp_mode_ff <= res_mode_ff;
         rsp_stop_ff <= res_stop_ff;
         rsp_kind_ff <= sp_kind_ff;
         rsp_value_ff <= value_in;
      end
   end

   assign rsp_source = rsp_source_ff;
   assign rsp_armed = rsp_armed_ff;
   assign rsp_active_throttle = rsp_thr_ff;
   assign rsp_start_cmd = rsp_start_ff;
   assign rsp_start_mode_out = rsp_mode_ff;
   assign rsp_stop_cmd = rsp_stop_ff;
   assign rsp_setpoint_kind = rsp_kind_ff;
   assign rsp_setpoint_value = rsp_value_ff;

`ifndef NO_ASSERTIONS
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> ((rsp_kind_ff != SP_TORQUE && rsp_kind_ff != SP_VOLT) ||
                        rsp_value_ff <= PCT_MAX))
      else $error("percent setpoint above full scale");

   a_start_stop: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !(res_start_ff && res_stop_ff))
      else $error("start and stop issued for the same tick");

   a_div_torque: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (sp_kind_ff == SP_TORQUE))
      else $error("divider running for a setpoint that needs no division");
`endif

endmodule

// ===== design/throttle_arming_setpoint_mapper.sv =====
`timescale 1ns / 1ps
// Top level: register file, sequencer and datapath of the throttle arming setpoint mapper.
//
//   Port group | Direction | Handshake
//   req_*      | in        | req_valid / req_ready, one tick or floor update per transfer
//   rsp_*      | out       | rsp_valid / rsp_ready, one result per accepted item
//   csr_*      | in/out    | psel / penable / pwrite, pready tied high
//
// An item passes through accept, two multiplies and the result load; a torque setpoint with a
// nonzero maximum current also runs the 15 steps of the restoring divider. Reset is synchronous
// and clears the arming state, the floors and the handshake state. A new item is taken while a
// result still waits for its transfer; the next result waits in the sequencer if needed.
module throttle_arming_setpoint_mapper
   import tasm_pkg::*;
#(
   parameter int ARM_TICKS = ARM_TICKS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [THR_W-1:0]      req_floor_value,
   input  logic                  req_usb_configured,
   input  logic [THR_W-1:0]      req_pot_throttle,
   input  logic                  req_pot_arm_request,
   input  logic                  req_pot_active,
   input  logic [THR_W-1:0]      req_custom_throttle,
   input  logic                  req_custom_arm_request,
   input  logic                  req_custom_active,
   input  logic [2:0]            req_motor_state,
   input  logic [1:0]            req_running_mode,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_source,
   output logic                  rsp_armed,
   output logic [THR_W-1:0]      rsp_active_throttle,
   output logic                  rsp_start_cmd,
   output logic [1:0]            rsp_start_mode_out,
   output logic                  rsp_stop_cmd,
   output logic [1:0]            rsp_setpoint_kind,
   output logic [VAL_W-1:0]      rsp_setpoint_value,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   tasm_cfg_type    cfg_ff;
   tasm_cmd_type    cmd;
   tasm_status_type status;
   logic            csr_wr;
   logic [2:0]      csr_index;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_index = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_select <= SEL_POT;
         cfg_ff.custom_present <= 1'b0;
         cfg_ff.start_mode <= '0;
         cfg_ff.min_speed <= '0;
         cfg_ff.max_speed <= '0;
         cfg_ff.min_current <= '0;
         cfg_ff.max_current <= '0;
         cfg_ff.min_voltage_frac <= '0;
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_SOURCE_SELECT: cfg_ff.source_select <= csr_pwdata[1:0];
            REG_CUSTOM_PRESENT: cfg_ff.custom_present <= csr_pwdata[0];
            REG_START_MODE: cfg_ff.start_mode <= csr_pwdata[2:0];
            REG_MIN_SPEED: cfg_ff.min_speed <= csr_pwdata[15:0];
            REG_MAX_SPEED: cfg_ff.max_speed <= csr_pwdata[15:0];
            REG_MIN_CURRENT: cfg_ff.min_current <= csr_pwdata[15:0];
            REG_MAX_CURRENT: cfg_ff.max_current <= csr_pwdata[15:0];
            REG_MIN_VOLTAGE: cfg_ff.min_voltage_frac <= csr_pwdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_SOURCE_SELECT: csr_prdata = CSR_DATA_W'(cfg_ff.source_select);
         REG_CUSTOM_PRESENT: csr_prdata = CSR_DATA_W'(cfg_ff.custom_present);
         REG_START_MODE: csr_prdata = CSR_DATA_W'(cfg_ff.start_mode);
         REG_MIN_SPEED: csr_prdata = CSR_DATA_W'(cfg_ff.min_speed);
         REG_MAX_SPEED: csr_prdata = CSR_DATA_W'(cfg_ff.max_speed);
         REG_MIN_CURRENT: csr_prdata = CSR_DATA_W'(cfg_ff.min_current);
         REG_MAX_CURRENT: csr_prdata = CSR_DATA_W'(cfg_ff.max_current);
         REG_MIN_VOLTAGE: csr_prdata = CSR_DATA_W'(cfg_ff.min_voltage_frac);
         default: csr_prdata = '0;
      endcase
   end

   tasm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tasm_dp #(
      .ARM_TICKS (ARM_TICKS)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .cfg                    (cfg_ff),
      .req_kind               (req_kind),
      .req_floor_value        (req_floor_value),
      .req_usb_configured     (req_usb_configured),
      .req_pot_throttle       (req_pot_throttle),
      .req_pot_arm_request    (req_pot_arm_request),
      .req_pot_active         (req_pot_active),
      .req_custom_throttle    (req_custom_throttle),
      .req_custom_arm_request (req_custom_arm_request),
      .req_custom_active      (req_custom_active),
      .req_motor_state        (req_motor_state),
      .req_running_mode       (req_running_mode),
      .rsp_source             (rsp_source),
      .rsp_armed              (rsp_armed),
      .rsp_active_throttle    (rsp_active_throttle),
      .rsp_start_cmd          (rsp_start_cmd),
      .rsp_start_mode_out     (rsp_start_mode_out),
      .rsp_stop_cmd           (rsp_stop_cmd),
      .rsp_setpoint_kind      (rsp_setpoint_kind),
      .rsp_setpoint_value     (rsp_setpoint_value)
   );

endmodule
